@@ hw/rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types for the sparse-set table
// Entity/slot widths, transfer payloads, memory entries and the microcode
// control word with its program.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int ENT_CAP   = 1024;
  localparam int ID_W      = $clog2(ENT_CAP);
  localparam int SLOT_W    = ID_W;
  localparam int CNT_W     = $clog2(ENT_CAP + 1);
  localparam int PAYLOAD_W = 32;
  localparam int SP_W      = 1 + SLOT_W;
  localparam int DN_W      = ID_W + PAYLOAD_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SC_OK      = 2'd0,
    SC_ABSENT  = 2'd1,
    SC_FULL    = 2'd2,
    SC_PRESENT = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_W-1:0]      entity_id;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    slot_index;
  } sst_in_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    dense_slot;
    logic [ID_W-1:0]      owner_entity;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [CNT_W-1:0]     live_count;
  } sst_out_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } sp_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]      owner;
    logic [PAYLOAD_W-1:0] data;
  } dn_entry_t;

  typedef struct packed {
    logic sp_hit;
    logic full;
    logic oor;
    logic hole_last;
    logic clr_more;
  } cond_flags_t;

  typedef enum logic [4:0] {
    U_CLR, U_WAIT,
    U_A0, U_A1, U_A2, U_A3,
    U_R0, U_R1, U_R2, U_R3, U_R4, U_R5, U_R6,
    U_L0, U_L1, U_L2, U_L3,
    U_D0, U_D1,
    U_E_ABS, U_E_FULL, U_E_PRES
  } ustep_t;

  typedef enum logic [2:0] {
    SP_NONE, SP_RD_ENT, SP_WR_NEW, SP_WR_CLR, SP_WR_MOVED, SP_WR_SWEEP
  } sp_op_t;

  typedef enum logic [2:0] {
    DN_NONE, DN_RD_SLOT, DN_RD_LAST, DN_RD_INDEX, DN_WR_COUNT, DN_WR_SLOT
  } dn_op_t;

  typedef enum logic [1:0] {
    LT_NONE, LT_SLOT, LT_GONE
  } latch_t;

  typedef enum logic [1:0] {
    CN_NONE, CN_INC, CN_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_ERR_ABS, RES_ERR_FULL, RES_ERR_PRES,
    RES_ADD, RES_GONE, RES_LOOK, RES_INDEX
  } res_t;

  typedef enum logic [3:0] {
    CD_NEXT, CD_ALWAYS, CD_SP_MISS, CD_SP_HIT, CD_FULL,
    CD_OOR, CD_HOLE_LAST, CD_CLR_MORE
  } cond_t;

  typedef struct packed {
    logic    wait_in;
    sp_op_t  sp_op;
    dn_op_t  dn_op;
    latch_t  latch;
    cnt_op_t cnt;
    res_t    res;
    cond_t   cond;
    ustep_t  target;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    wait_in: 1'b0, sp_op: SP_NONE, dn_op: DN_NONE, latch: LT_NONE,
    cnt: CN_NONE, res: RES_NONE, cond: CD_NEXT, target: U_WAIT
  };

  function automatic ustep_t op_entry(op_t op);
    ustep_t s;
    unique case (op)
      OP_ADD:    s = U_A0;
      OP_REMOVE: s = U_R0;
      OP_LOOKUP: s = U_L0;
      OP_READ:   s = U_D0;
      default:   s = U_WAIT;
    endcase
    return s;
  endfunction

  function automatic ucw_t ucode(ustep_t s);
    ucw_t w;
    w = UCW_NOP;
    unique case (s)
      U_CLR: begin
        w.sp_op  = SP_WR_SWEEP;
        w.cond   = CD_CLR_MORE;
        w.target = U_CLR;
      end
      U_WAIT: w.wait_in = 1'b1;
      U_A0:   w.sp_op = SP_RD_ENT;
      U_A1: begin
        w.cond   = CD_SP_HIT;
        w.target = U_E_PRES;
      end
      U_A2: begin
        w.cond   = CD_FULL;
        w.target = U_E_FULL;
      end
      U_A3: begin
        w.sp_op = SP_WR_NEW;
        w.dn_op = DN_WR_COUNT;
        w.cnt   = CN_INC;
        w.res   = RES_ADD;
        w.cond  = CD_ALWAYS;
      end
      U_R0:   w.sp_op = SP_RD_ENT;
      U_R1: begin
        w.latch  = LT_SLOT;
        w.cond   = CD_SP_MISS;
        w.target = U_E_ABS;
      end
      U_R2:   w.dn_op = DN_RD_SLOT;
      U_R3: begin
        w.latch = LT_GONE;
        w.dn_op = DN_RD_LAST;
      end
      U_R4: begin
        w.cond   = CD_HOLE_LAST;
        w.target = U_R6;
      end
      U_R5: begin
        w.dn_op = DN_WR_SLOT;
        w.sp_op = SP_WR_MOVED;
      end
      U_R6: begin
        w.sp_op = SP_WR_CLR;
        w.cnt   = CN_DEC;
        w.res   = RES_GONE;
        w.cond  = CD_ALWAYS;
      end
      U_L0:   w.sp_op = SP_RD_ENT;
      U_L1: begin
        w.latch  = LT_SLOT;
        w.cond   = CD_SP_MISS;
        w.target = U_E_ABS;
      end
      U_L2:   w.dn_op = DN_RD_SLOT;
      U_L3: begin
        w.res  = RES_LOOK;
        w.cond = CD_ALWAYS;
      end
      U_D0: begin
        w.dn_op  = DN_RD_INDEX;
        w.cond   = CD_OOR;
        w.target = U_E_ABS;
      end
      U_D1: begin
        w.res  = RES_INDEX;
        w.cond = CD_ALWAYS;
      end
      U_E_ABS: begin
        w.res  = RES_ERR_ABS;
        w.cond = CD_ALWAYS;
      end
      U_E_FULL: begin
        w.res  = RES_ERR_FULL;
        w.cond = CD_ALWAYS;
      end
      U_E_PRES: begin
        w.res  = RES_ERR_PRES;
        w.cond = CD_ALWAYS;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sst_ram.sv @@
// ----------------------------------------------------------------------------
// sst_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem_r[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/sst_useq.sv @@
// ----------------------------------------------------------------------------
// sst_useq: microcode sequencer
// Step counter over the control store, with opcode dispatch, conditional
// jumps and a hold on result steps while the result register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_useq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sst_pkg::cond_flags_t flags,
  input  wire logic                 in_valid,
  input  wire sst_pkg::op_t         in_op,
  input  wire logic                 out_busy,
  output sst_pkg::ucw_t             ucw,
  output logic                      adv
);

  sst_pkg::ustep_t step_r;
  sst_pkg::ustep_t step_nxt;
  sst_pkg::ustep_t step_inc;
  logic            taken;

  always_comb begin
    ucw = sst_pkg::ucode(step_r);
    if (ucw.wait_in) begin
      adv = in_valid;
    end else begin
      adv = !((ucw.res != sst_pkg::RES_NONE) && out_busy);
    end
  end

  always_comb begin
    step_inc = sst_pkg::ustep_t'(step_r + 5'd1);
    unique case (ucw.cond)
      sst_pkg::CD_NEXT:      taken = 1'b0;
      sst_pkg::CD_ALWAYS:    taken = 1'b1;
      sst_pkg::CD_SP_MISS:   taken = !flags.sp_hit;
      sst_pkg::CD_SP_HIT:    taken = flags.sp_hit;
      sst_pkg::CD_FULL:      taken = flags.full;
      sst_pkg::CD_OOR:       taken = flags.oor;
      sst_pkg::CD_HOLE_LAST: taken = flags.hole_last;
      sst_pkg::CD_CLR_MORE:  taken = flags.clr_more;
      default:               taken = 1'b0;
    endcase
    priority if (!adv) begin
      step_nxt = step_r;
    end else if (ucw.wait_in) begin
      step_nxt = sst_pkg::op_entry(in_op);
    end else if (taken) begin
      step_nxt = ucw.target;
    end else begin
      step_nxt = step_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= sst_pkg::U_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sparse_set_swap_remove_table_core.sv @@
// One item in flight: in_ready is high only in the wait step, so a new
// item is taken only after the last one has finished, bounded by the
// single-port sparse and dense memories and the microcode step count.
// Reset: synchronous active-low; clears the count, then sweeps every entry
// of the sparse map with in_ready low before the first item is taken.
// ----------------------------------------------------------------------------
// sparse_set_swap_remove_table_core: sparse-set table with swap-remove
// Sparse map and dense store in single-port RAMs, driven by a microcoded
// sequencer; results leave through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_set_swap_remove_table_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sst_pkg::sst_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sst_pkg::sst_out_t     out_data
);

  sst_pkg::ucw_t        ucw;
  logic                 adv;
  sst_pkg::cond_flags_t flags;

  sst_pkg::sst_in_t     in_r;
  logic [sst_pkg::CNT_W-1:0]  count_r;
  logic [sst_pkg::CNT_W-1:0]  count_nxt;
  logic [sst_pkg::CNT_W-1:0]  last_cnt;
  logic [sst_pkg::SLOT_W-1:0] clr_cnt_r;
  logic [sst_pkg::SLOT_W-1:0] slot_r;
  sst_pkg::dn_entry_t   gone_r;
  logic                 out_valid_r;
  sst_pkg::sst_out_t    out_data_r;
  sst_pkg::sst_out_t    res;

  logic                       sp_en;
  logic                       sp_we;
  logic [sst_pkg::ID_W-1:0]   sp_addr;
  sst_pkg::sp_entry_t         sp_wdata;
  sst_pkg::sp_entry_t         sp_rd;
  logic                       dn_en;
  logic                       dn_we;
  logic [sst_pkg::SLOT_W-1:0] dn_addr;
  sst_pkg::dn_entry_t         dn_wdata;
  sst_pkg::dn_entry_t         dn_rd;

  sst_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flags    (flags),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .out_busy (out_valid_r && !out_ready),
    .ucw      (ucw),
    .adv      (adv)
  );

  sst_ram #(.WIDTH(sst_pkg::SP_W), .DEPTH(sst_pkg::ENT_CAP)) u_sparse (
    .clk   (clk),
    .en    (sp_en),
    .we    (sp_we),
    .addr  (sp_addr),
    .wdata (sp_wdata),
    .rdata (sp_rd)
  );

  sst_ram #(.WIDTH(sst_pkg::DN_W), .DEPTH(sst_pkg::ENT_CAP)) u_dense (
    .clk   (clk),
    .en    (dn_en),
    .we    (dn_we),
    .addr  (dn_addr),
    .wdata (dn_wdata),
    .rdata (dn_rd)
  );

  assign in_ready  = ucw.wait_in;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign last_cnt  = count_r - sst_pkg::CNT_W'(1);

  always_comb begin
    flags.sp_hit    = sp_rd.valid;
    flags.full      = (count_r == sst_pkg::CNT_W'(sst_pkg::ENT_CAP));
    flags.oor       = ({1'b0, in_r.slot_index} >= count_r);
    flags.hole_last = ({1'b0, slot_r} == last_cnt);
    flags.clr_more  = (clr_cnt_r != '1);
  end

  always_comb begin
    sp_en    = 1'b0;
    sp_we    = 1'b0;
    sp_addr  = in_r.entity_id;
    sp_wdata = '0;
    unique case (ucw.sp_op)
      sst_pkg::SP_NONE: ;
      sst_pkg::SP_RD_ENT: sp_en = adv;
      sst_pkg::SP_WR_NEW: begin
        sp_en    = adv;
        sp_we    = 1'b1;
        sp_wdata = '{valid: 1'b1, slot: count_r[sst_pkg::SLOT_W-1:0]};
      end
      sst_pkg::SP_WR_CLR: begin
        sp_en = adv;
        sp_we = 1'b1;
      end
      sst_pkg::SP_WR_MOVED: begin
        sp_en    = adv;
        sp_we    = 1'b1;
        sp_addr  = dn_rd.owner;
        sp_wdata = '{valid: 1'b1, slot: slot_r};
      end
      sst_pkg::SP_WR_SWEEP: begin
        sp_en   = adv;
        sp_we   = 1'b1;
        sp_addr = clr_cnt_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    dn_en    = 1'b0;
    dn_we    = 1'b0;
    dn_addr  = slot_r;
    dn_wdata = dn_rd;
    unique case (ucw.dn_op)
      sst_pkg::DN_NONE: ;
      sst_pkg::DN_RD_SLOT: dn_en = adv;
      sst_pkg::DN_RD_LAST: begin
        dn_en   = adv;
        dn_addr = last_cnt[sst_pkg::SLOT_W-1:0];
      end
      sst_pkg::DN_RD_INDEX: begin
        dn_en   = adv;
        dn_addr = in_r.slot_index;
      end
      sst_pkg::DN_WR_COUNT: begin
        dn_en    = adv;
        dn_we    = 1'b1;
        dn_addr  = count_r[sst_pkg::SLOT_W-1:0];
        dn_wdata = '{owner: in_r.entity_id, data: in_r.payload};
      end
      sst_pkg::DN_WR_SLOT: begin
        dn_en = adv;
        dn_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (adv) begin
      unique case (ucw.cnt)
        sst_pkg::CN_NONE: ;
        sst_pkg::CN_INC:  count_nxt = count_r + sst_pkg::CNT_W'(1);
        sst_pkg::CN_DEC:  count_nxt = last_cnt;
        default: ;
      endcase
    end
  end

  always_comb begin
    res            = '0;
    res.live_count = count_nxt;
    unique case (ucw.res)
      sst_pkg::RES_NONE: ;
      sst_pkg::RES_ERR_ABS:  res.status = sst_pkg::SC_ABSENT;
      sst_pkg::RES_ERR_FULL: res.status = sst_pkg::SC_FULL;
      sst_pkg::RES_ERR_PRES: res.status = sst_pkg::SC_PRESENT;
      sst_pkg::RES_ADD: begin
        res.dense_slot   = count_r[sst_pkg::SLOT_W-1:0];
        res.owner_entity = in_r.entity_id;
        res.payload_out  = in_r.payload;
      end
      sst_pkg::RES_GONE: begin
        res.dense_slot   = slot_r;
        res.owner_entity = gone_r.owner;
        res.payload_out  = gone_r.data;
      end
      sst_pkg::RES_LOOK: begin
        res.dense_slot   = slot_r;
        res.owner_entity = dn_rd.owner;
        res.payload_out  = dn_rd.data;
      end
      sst_pkg::RES_INDEX: begin
        res.dense_slot   = in_r.slot_index;
        res.owner_entity = dn_rd.owner;
        res.payload_out  = dn_rd.data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (adv && (ucw.sp_op == sst_pkg::SP_WR_SWEEP)) begin
        clr_cnt_r <= clr_cnt_r + sst_pkg::SLOT_W'(1);
      end
      if (adv && (ucw.res != sst_pkg::RES_NONE)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.wait_in && in_valid) begin
      in_r <= in_data;
    end
    if (adv && (ucw.latch == sst_pkg::LT_SLOT)) begin
      slot_r <= sp_rd.slot;
    end
    if (adv && (ucw.latch == sst_pkg::LT_GONE)) begin
      gone_r <= dn_rd;
    end
    if (adv && (ucw.res != sst_pkg::RES_NONE)) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker: port-level checks for the sparse-set table
// Watches the transfer ports of the top level; bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire sst_pkg::sst_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sst_pkg::sst_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != sst_pkg::SC_OK) |->
      (out_data.dense_slot == '0) && (out_data.owner_entity == '0) &&
      (out_data.payload_out == '0))
    else $error("refused result carries entry data");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.live_count <= sst_pkg::CNT_W'(sst_pkg::ENT_CAP)) &&
      ((out_data.status != sst_pkg::SC_FULL) ||
       (out_data.live_count == sst_pkg::CNT_W'(sst_pkg::ENT_CAP))))
    else $error("live count out of range or full status with room left");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken before sparse map sweep");

endmodule

bind sparse_set_swap_remove_table_core sst_checker u_sst_checker (.*);

`default_nettype wire
